>>> hdl/tns_pkg.sv
package tns_pkg;

    localparam int COORD_W        = 24;
    localparam int SIZE_W         = 12;
    localparam int TEXEL_ADDR_W   = 16;
    localparam int TEXEL_W        = 32;
    localparam int COLOR_W        = 8;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 12;
    localparam int STATUS_W       = 2;

    localparam int TEXEL_COUNT_DEFAULT     = 65536;
    localparam int COORD_FRAC_BITS_DEFAULT = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEX_WIDTH      = 3'd0,
        REG_TEX_HEIGHT     = 3'd1,
        REG_WRAP_S         = 3'd2,
        REG_WRAP_T         = 3'd3,
        REG_TEXTURE_STATUS = 3'd4
    } cfg_reg_t;

    localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FAILED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PRESENT = 2'd2;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

endpackage

>>> hdl/texture_nearest_sampler.sv
// Nearest-neighbor texture sampler.
// Input channel (in_valid/in_ready) carries one item per transfer: kind 0
// writes texel_word into the texel memory at texel_addr, kind 1 samples the
// texture at the signed fixed-point coordinates u_coord, v_coord.
// Output channel (out_valid/out_ready) carries one result per sample item:
// red, green, blue of the picked texel and no_color; write items give none.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register
// per edge; users must write only while no item is in flight, unchecked.
// Throughput: one item per cycle while in_ready is high. Every sample runs
// through nine register stages (axis reduce, scale multiply, floor and
// limit, row-major address, two reciprocal multiplies and a fixup for the
// memory modulo, memory access, output register); writes retire at memory
// access. Writes and reads hit the single memory port in transfer order.
// Reset clears the configuration to width 1, height 1, repeat on both axes,
// no texture, and empties all stages; the texel memory keeps no reset.
// When the receiver stalls, the result holds in the output register and
// earlier stages keep filling their bubbles; in_ready drops only once the
// output register is full and not taken and every stage behind it holds.
module texture_nearest_sampler
    import tns_pkg::*;
#(
    parameter int TEXEL_COUNT     = TEXEL_COUNT_DEFAULT,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      kind,
    input  logic [COORD_W-1:0]        u_coord,
    input  logic [COORD_W-1:0]        v_coord,
    input  logic [TEXEL_ADDR_W-1:0]   texel_addr,
    input  logic [TEXEL_W-1:0]        texel_word,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [COLOR_W-1:0]        red,
    output logic [COLOR_W-1:0]        green,
    output logic [COLOR_W-1:0]        blue,
    output logic                      no_color
);

    localparam int T_W     = COORD_FRAC_BITS + 1;
    localparam int CMP_W   = COORD_W + 2;
    localparam int P_W     = T_W + SIZE_W;
    localparam int IDX_W   = SIZE_W + 1;
    localparam int LIN_W   = 24;
    localparam int ADDR_W  = (TEXEL_COUNT > 1) ? $clog2(TEXEL_COUNT) : 1;
    localparam int RECIP_SHIFT = LIN_W + $clog2(TEXEL_COUNT);
    localparam int RECIP_W = LIN_W + 2;
    localparam int PROD_W  = LIN_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(TEXEL_COUNT) - 64'd1) / 64'(TEXEL_COUNT);
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP_FULL);
    localparam logic [LIN_W-1:0] TC_L = LIN_W'(TEXEL_COUNT);
    localparam logic signed [CMP_W-1:0] ONE_S = CMP_W'(64'd1 << COORD_FRAC_BITS);

    // Configuration
    logic [SIZE_W-1:0]   tex_width_reg;
    logic [SIZE_W-1:0]   tex_height_reg;
    logic                wrap_s_reg;
    logic                wrap_t_reg;
    logic [STATUS_W-1:0] texture_status_reg;
    logic [SIZE_W-1:0]   w_eff;
    logic [SIZE_W-1:0]   h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg      <= SIZE_W'(1);
            tex_height_reg     <= SIZE_W'(1);
            wrap_s_reg         <= 1'b1;
            wrap_t_reg         <= 1'b1;
            texture_status_reg <= STATUS_NONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEX_WIDTH:      tex_width_reg      <= cfg_data[SIZE_W-1:0];
                REG_TEX_HEIGHT:     tex_height_reg     <= cfg_data[SIZE_W-1:0];
                REG_WRAP_S:         wrap_s_reg         <= cfg_data[0];
                REG_WRAP_T:         wrap_t_reg         <= cfg_data[0];
                REG_TEXTURE_STATUS: texture_status_reg <= cfg_data[STATUS_W-1:0];
                default:            ;
            endcase
        end
    end

    assign w_eff = (tex_width_reg == '0) ? SIZE_W'(1) : tex_width_reg;
    assign h_eff = (tex_height_reg == '0) ? SIZE_W'(1) : tex_height_reg;

    function automatic logic [T_W-1:0] axis_reduce(input logic [COORD_W-1:0] raw,
                                                  input logic rpt);
        logic signed [CMP_W-1:0] s;
        logic [T_W-1:0] t;
        begin
            s = CMP_W'($signed(raw));
            if (rpt)
                t = T_W'(raw[COORD_FRAC_BITS-1:0]);
            else if (s < 0)
                t = '0;
            else if (s > ONE_S)
                t = T_W'(ONE_S);
            else
                t = T_W'(s);
            return t;
        end
    endfunction

    function automatic logic [SIZE_W-1:0] index_limit(input logic [P_W-1:0] prod,
                                                     input logic [SIZE_W-1:0] size);
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] top;
        begin
            idx = IDX_W'(prod >> COORD_FRAC_BITS);
            top = IDX_W'(size) - IDX_W'(1);
            if (idx > top)
                idx = top;
            return idx[SIZE_W-1:0];
        end
    endfunction

    // Stage control: a stage loads when it is empty or its item moves on
    logic [9:1] valid_reg;
    logic [9:1] ld;

    assign ld[9] = !valid_reg[9] || out_ready;
    assign ld[8] = !valid_reg[8] || ld[9];
    assign ld[7] = !valid_reg[7] || ld[8];
    assign ld[6] = !valid_reg[6] || ld[7];
    assign ld[5] = !valid_reg[5] || ld[6];
    assign ld[4] = !valid_reg[4] || ld[5];
    assign ld[3] = !valid_reg[3] || ld[4];
    assign ld[2] = !valid_reg[2] || ld[3];
    assign ld[1] = !valid_reg[1] || ld[2];
    assign in_ready = ld[1];

    // Stage payload
    logic                    sample1_reg, sample2_reg, sample3_reg, sample4_reg;
    logic                    sample5_reg, sample6_reg, sample7_reg;
    logic                    wr_ok1_reg, wr_ok2_reg, wr_ok3_reg, wr_ok4_reg;
    logic                    wr_ok5_reg, wr_ok6_reg, wr_ok7_reg;
    logic [TEXEL_W-1:0]      word1_reg, word2_reg, word3_reg, word4_reg;
    logic [TEXEL_W-1:0]      word5_reg, word6_reg, word7_reg;
    logic [TEXEL_ADDR_W-1:0] addr1_reg, addr2_reg, addr3_reg;
    logic [T_W-1:0]          tx1_reg, ty1_reg;
    logic [P_W-1:0]          px2_reg, py2_reg;
    logic [SIZE_W-1:0]       x3_reg, y3_reg;
    logic [LIN_W-1:0]        lin4_reg, lin5_reg, lin6_reg;
    logic [LIN_W-1:0]        q5_reg;
    logic [LIN_W-1:0]        qd6_reg;
    logic [ADDR_W-1:0]       r7_reg;
    logic [TEXEL_W-1:0]      rdata8_reg;

    logic [LIN_W-1:0]        lin4_next;
    logic [PROD_W-1:0]       qprod;
    logic [LIN_W-1:0]        diff6;
    logic [LIN_W-1:0]        r7_next;

    always_comb
    begin
        if (sample3_reg)
            lin4_next = LIN_W'(w_eff) * LIN_W'(y3_reg) + LIN_W'(x3_reg);
        else
            lin4_next = LIN_W'(addr3_reg);
        qprod = PROD_W'(lin4_reg) * PROD_W'(RECIP_C);
        diff6 = lin6_reg - qd6_reg;
        r7_next = (diff6 >= TC_L) ? diff6 - TC_L : diff6;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ld[1]) valid_reg[1] <= in_valid;
            if (ld[2]) valid_reg[2] <= valid_reg[1];
            if (ld[3]) valid_reg[3] <= valid_reg[2];
            if (ld[4]) valid_reg[4] <= valid_reg[3];
            if (ld[5]) valid_reg[5] <= valid_reg[4];
            if (ld[6]) valid_reg[6] <= valid_reg[5];
            if (ld[7]) valid_reg[7] <= valid_reg[6];
            // writes retire in the memory stage
            if (ld[8]) valid_reg[8] <= valid_reg[7] && sample7_reg;
            if (ld[9]) valid_reg[9] <= valid_reg[8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            sample1_reg <= (kind == KIND_SAMPLE);
            wr_ok1_reg  <= (LIN_W'(texel_addr) < TC_L);
            word1_reg   <= texel_word;
            addr1_reg   <= texel_addr;
            tx1_reg     <= axis_reduce(u_coord, wrap_s_reg);
            ty1_reg     <= axis_reduce(v_coord, wrap_t_reg);
        end
        if (ld[2])
        begin
            sample2_reg <= sample1_reg;
            wr_ok2_reg  <= wr_ok1_reg;
            word2_reg   <= word1_reg;
            addr2_reg   <= addr1_reg;
            px2_reg     <= P_W'(tx1_reg) * P_W'(w_eff);
            py2_reg     <= P_W'(ty1_reg) * P_W'(h_eff);
        end
        if (ld[3])
        begin
            sample3_reg <= sample2_reg;
            wr_ok3_reg  <= wr_ok2_reg;
            word3_reg   <= word2_reg;
            addr3_reg   <= addr2_reg;
            x3_reg      <= index_limit(px2_reg, w_eff);
            y3_reg      <= index_limit(py2_reg, h_eff);
        end
        if (ld[4])
        begin
            sample4_reg <= sample3_reg;
            wr_ok4_reg  <= wr_ok3_reg;
            word4_reg   <= word3_reg;
            lin4_reg    <= lin4_next;
        end
        if (ld[5])
        begin
            sample5_reg <= sample4_reg;
            wr_ok5_reg  <= wr_ok4_reg;
            word5_reg   <= word4_reg;
            lin5_reg    <= lin4_reg;
            q5_reg      <= LIN_W'(qprod >> RECIP_SHIFT);
        end
        if (ld[6])
        begin
            sample6_reg <= sample5_reg;
            wr_ok6_reg  <= wr_ok5_reg;
            word6_reg   <= word5_reg;
            lin6_reg    <= lin5_reg;
            // true product never exceeds the address, so the low bits suffice
            qd6_reg     <= q5_reg * TC_L;
        end
        if (ld[7])
        begin
            sample7_reg <= sample6_reg;
            wr_ok7_reg  <= wr_ok6_reg;
            word7_reg   <= word6_reg;
            r7_reg      <= r7_next[ADDR_W-1:0];
        end
    end

    // Texel memory: one port, write and read in transfer order
    logic [TEXEL_W-1:0] texel_mem [TEXEL_COUNT];

    always_ff @(posedge clk)
    begin
        if (ld[8] && valid_reg[7])
        begin
            if (sample7_reg)
                rdata8_reg <= texel_mem[r7_reg];
            else if (wr_ok7_reg)
                texel_mem[r7_reg] <= word7_reg;
        end
    end

    // Output register
    logic [COLOR_W-1:0] red_reg, green_reg, blue_reg;
    logic               no_color_reg;

    always_ff @(posedge clk)
    begin
        if (ld[9])
        begin
            unique case (texture_status_reg)
                STATUS_FAILED:
                begin
                    red_reg      <= '1;
                    green_reg    <= '1;
                    blue_reg     <= '1;
                    no_color_reg <= 1'b0;
                end
                STATUS_PRESENT:
                begin
                    red_reg      <= rdata8_reg[23:16];
                    green_reg    <= rdata8_reg[15:8];
                    blue_reg     <= rdata8_reg[7:0];
                    no_color_reg <= 1'b0;
                end
                default:
                begin
                    red_reg      <= '0;
                    green_reg    <= '0;
                    blue_reg     <= '0;
                    no_color_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid = valid_reg[9];
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign no_color  = no_color_reg;

endmodule

>>> hdl/tns_checker.sv
module tns_checker
    import tns_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    cfg_we,
    input logic [CFG_INDEX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0]   cfg_data,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    kind,
    input logic [COORD_W-1:0]      u_coord,
    input logic [COORD_W-1:0]      v_coord,
    input logic [TEXEL_ADDR_W-1:0] texel_addr,
    input logic [TEXEL_W-1:0]      texel_word,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [COLOR_W-1:0]      red,
    input logic [COLOR_W-1:0]      green,
    input logic [COLOR_W-1:0]      blue,
    input logic                    no_color
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue) && $stable(no_color))
        else $error("stalled result changed");

    a_no_color_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_color |-> red == '0 && green == '0 && blue == '0)
        else $error("no_color result carries color");

    // input backs up only behind a stalled output register
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind texture_nearest_sampler tns_checker u_tns_checker (.*);

>>> tb/sv/sampler_color_checker.sv
module sampler_color_checker
    import tns_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    kind,
    input  logic [COORD_W-1:0]      u_coord,
    input  logic [COORD_W-1:0]      v_coord,
    input  logic [TEXEL_ADDR_W-1:0] texel_addr,
    input  logic [TEXEL_W-1:0]      texel_word,

    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [COLOR_W-1:0]      red,
    input  logic [COLOR_W-1:0]      green,
    input  logic [COLOR_W-1:0]      blue,
    input  logic                    no_color,

    output int                      errors,
    output int                      pending
);

    localparam int FRAC      = COORD_FRAC_BITS_DEFAULT;
    localparam int MEM_DEPTH = TEXEL_COUNT_DEFAULT;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               no_color;
    } color_t;

    logic [TEXEL_W-1:0]  texel_mem [0:MEM_DEPTH-1];
    logic [SIZE_W-1:0]   width_q;
    logic [SIZE_W-1:0]   height_q;
    logic                wrap_s_q;
    logic                wrap_t_q;
    logic [STATUS_W-1:0] status_q;
    color_t              expected_colors [$];
    color_t              want;
    int                  mismatch_count;

    // Reduce one coordinate to [0, 1.0] and scale it to a texel index below size.
    function automatic int unsigned axis_pick(logic [COORD_W-1:0] raw, logic rep,
                                              logic [SIZE_W-1:0] size);
        int unsigned span;
        int unsigned t;
        int unsigned idx;
        span = (size == 0) ? 1 : 32'(size);
        if (rep)
            t = 32'(raw[FRAC-1:0]);
        else if (raw[COORD_W-1])
            t = 0;
        else if (raw > (1 << FRAC))
            t = 1 << FRAC;
        else
            t = 32'(raw);
        idx = (t * span) >> FRAC;
        if (idx > span - 1)
            idx = span - 1;
        return idx;
    endfunction

    function automatic color_t sample_color(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        color_t                  c;
        int unsigned             w;
        logic [TEXEL_ADDR_W-1:0] a;
        logic [TEXEL_W-1:0]      word;
        c = '0;
        if (status_q == STATUS_FAILED)
        begin
            c.red   = '1;
            c.green = '1;
            c.blue  = '1;
        end
        else if (status_q != STATUS_PRESENT)
            c.no_color = 1'b1;
        else
        begin
            w = (width_q == 0) ? 1 : 32'(width_q);
            // address range equals the memory depth, so truncation is the modulo
            a = TEXEL_ADDR_W'(w * axis_pick(v, wrap_t_q, height_q)
                              + axis_pick(u, wrap_s_q, width_q));
            word    = texel_mem[a];
            c.red   = word[23:16];
            c.green = word[15:8];
            c.blue  = word[7:0];
        end
        return c;
    endfunction

    task automatic compare_field(string field, logic [COLOR_W-1:0] exp_v,
                                 logic [COLOR_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s expected %h got %h", $time, field, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_q        = 1;
            height_q       = 1;
            wrap_s_q       = 1'b1;
            wrap_t_q       = 1'b1;
            status_q       = STATUS_NONE;
            mismatch_count = 0;
            expected_colors.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TEX_WIDTH:      width_q  = cfg_data[SIZE_W-1:0];
                    REG_TEX_HEIGHT:     height_q = cfg_data[SIZE_W-1:0];
                    REG_WRAP_S:         wrap_s_q = cfg_data[0];
                    REG_WRAP_T:         wrap_t_q = cfg_data[0];
                    REG_TEXTURE_STATUS: status_q = cfg_data[STATUS_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $display("%0t: result expected none got red %h green %h blue %h no_color %b",
                             $time, red, green, blue, no_color);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    compare_field("red", want.red, red);
                    compare_field("green", want.green, green);
                    compare_field("blue", want.blue, blue);
                    compare_field("no_color", COLOR_W'(want.no_color), COLOR_W'(no_color));
                end
            end

            // predict in transfer order: writes land before any later sample reads them
            if (in_valid && in_ready)
            begin
                if (kind == KIND_WRITE)
                    texel_mem[texel_addr] = texel_word;
                else
                    expected_colors.push_back(sample_color(u_coord, v_coord));
            end

            errors  <= mismatch_count;
            pending <= expected_colors.size();
        end
    end

endmodule

>>> tb/sv/tb_texture_nearest_sampler.sv
module tb_texture_nearest_sampler;
    import tns_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 120;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 32;
    localparam int RUN_LIMIT    = 3000000;
    localparam int FRAC         = COORD_FRAC_BITS_DEFAULT;

    localparam logic [COORD_W-1:0]  COORD_ONE     = COORD_W'(1 << FRAC);
    localparam logic [COORD_W-1:0]  COORD_MIN     = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0]  COORD_MAX     = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0]  COORD_NEG_LSB = '1;
    localparam logic [STATUS_W-1:0] STATUS_SPARE  = '1;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    kind;
    logic [COORD_W-1:0]      u_coord;
    logic [COORD_W-1:0]      v_coord;
    logic [TEXEL_ADDR_W-1:0] texel_addr;
    logic [TEXEL_W-1:0]      texel_word;
    logic                    out_valid;
    logic                    out_ready;
    logic [COLOR_W-1:0]      red;
    logic [COLOR_W-1:0]      green;
    logic [COLOR_W-1:0]      blue;
    logic                    no_color;
    int                      errors;
    int                      pending;

    // register image as last written, used to aim samples at written texels
    logic [SIZE_W-1:0]   sh_width;
    logic [SIZE_W-1:0]   sh_height;
    logic                sh_wrap_s;
    logic                sh_wrap_t;
    logic [STATUS_W-1:0] sh_status;
    bit                  texel_written [TEXEL_COUNT_DEFAULT];

    int  burst_left;
    int  writes_sent;
    int  samples_sent;
    int  settings_used;
    bit  hold_req;

    texture_nearest_sampler dut (.*);

    sampler_color_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned axis_cell(logic [COORD_W-1:0] raw, logic rep,
                                              logic [SIZE_W-1:0] size);
        int unsigned span;
        int unsigned t;
        int unsigned idx;
        span = (size == 0) ? 1 : 32'(size);
        if (rep)
            t = 32'(raw[FRAC-1:0]);
        else if (raw[COORD_W-1])
            t = 0;
        else if (raw > (1 << FRAC))
            t = 1 << FRAC;
        else
            t = 32'(raw);
        idx = (t * span) >> FRAC;
        if (idx > span - 1)
            idx = span - 1;
        return idx;
    endfunction

    function automatic logic [TEXEL_ADDR_W-1:0] texel_index(logic [COORD_W-1:0] u,
                                                            logic [COORD_W-1:0] v);
        int unsigned w;
        w = (sh_width == 0) ? 1 : 32'(sh_width);
        return TEXEL_ADDR_W'(w * axis_cell(v, sh_wrap_t, sh_height)
                             + axis_cell(u, sh_wrap_s, sh_width));
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return COORD_W'($urandom);
            1:
            begin
                case ($urandom_range(0, 6))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return '0;
                    3: return COORD_ONE;
                    4: return COORD_ONE - COORD_W'(1);
                    5: return COORD_ONE + COORD_W'(1);
                    default: return COORD_NEG_LSB;
                endcase
            end
            2, 3: return COORD_W'($urandom_range(0, 4 << FRAC) - (2 << FRAC));
            default: return COORD_W'($urandom_range(0, 1 << FRAC));
        endcase
    endfunction

    // Offer one item in bursts with random gaps; return once it has transferred.
    task automatic offer(logic k, logic [COORD_W-1:0] u, logic [COORD_W-1:0] v,
                         logic [TEXEL_ADDR_W-1:0] a, logic [TEXEL_W-1:0] w);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid   <= 1'b1;
        kind       <= k;
        u_coord    <= u;
        v_coord    <= v;
        texel_addr <= a;
        texel_word <= w;
        do @(posedge clk); while (!in_ready);
        if (k == KIND_WRITE)
            writes_sent++;
        else
            samples_sent++;
    endtask

    task automatic write_texel(logic [TEXEL_ADDR_W-1:0] a, logic [TEXEL_W-1:0] w);
        offer(KIND_WRITE, COORD_W'($urandom), COORD_W'($urandom), a, w);
        texel_written[a] = 1'b1;
    endtask

    task automatic sample_at(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        logic [TEXEL_ADDR_W-1:0] a;
        if (sh_status == STATUS_PRESENT)
        begin
            a = texel_index(u, v);
            // never read a texel the memory has not seen yet
            if (!texel_written[a])
                write_texel(a, $urandom);
        end
        offer(KIND_SAMPLE, u, v, TEXEL_ADDR_W'($urandom), $urandom);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    // Drain the pipeline, then rewrite every register.
    task automatic set_regs(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, logic ws,
                            logic wt, logic [STATUS_W-1:0] st);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_TEX_WIDTH, w);
        write_reg(REG_TEX_HEIGHT, h);
        // upper data bits of the narrow registers carry noise
        write_reg(REG_WRAP_S, {(CFG_DATA_W-1)'($urandom), ws});
        write_reg(REG_WRAP_T, {(CFG_DATA_W-1)'($urandom), wt});
        write_reg(REG_TEXTURE_STATUS, {(CFG_DATA_W-STATUS_W)'($urandom), st});
        write_reg(CFG_INDEX_W'(REG_TEXTURE_STATUS) + CFG_INDEX_W'($urandom_range(1, 3)),
                  CFG_DATA_W'($urandom));
        cfg_we    <= 1'b0;
        sh_width  = w;
        sh_height = h;
        sh_wrap_s = ws;
        sh_wrap_t = wt;
        sh_status = st;
        settings_used++;
    endtask

    // receiver: periodic stall pattern, re-rolled now and then, plus one long hold-off
    initial
    begin
        int unsigned rx_cycle;
        int unsigned period;
        int unsigned stall_len;
        bit          hold_done;
        out_ready = 1'b0;
        rx_cycle  = 0;
        period    = 8;
        stall_len = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (rx_cycle % 256 == 0)
            begin
                period    = $urandom_range(3, 12);
                stall_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, period - 1);
            end
            out_ready <= (rx_cycle % period) >= stall_len;
            rx_cycle++;
        end
    end

    initial
    begin
        int                  p;
        logic [SIZE_W-1:0]   w;
        logic [SIZE_W-1:0]   h;
        logic                ws;
        logic                wt;
        logic [STATUS_W-1:0] st;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        kind          = KIND_WRITE;
        u_coord       = '0;
        v_coord       = '0;
        texel_addr    = '0;
        texel_word    = '0;
        hold_req      = 1'b0;
        burst_left    = 0;
        writes_sent   = 0;
        samples_sent  = 0;
        settings_used = 0;
        sh_width      = 1;
        sh_height     = 1;
        sh_wrap_s     = 1'b1;
        sh_wrap_t     = 1'b1;
        sh_status     = STATUS_NONE;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no texture straight out of reset, then the unused status and the failed load
        sample_at(COORD_ONE, '0);
        set_regs(1, 1, 1'b1, 1'b1, STATUS_SPARE);
        sample_at(COORD_NEG_LSB, COORD_NEG_LSB);
        set_regs(1, 1, 1'b1, 1'b1, STATUS_FAILED);
        sample_at(COORD_MAX, COORD_MIN);

        // 2x2 texture with extreme texel words, repeat on both axes
        set_regs(2, 2, 1'b1, 1'b1, STATUS_PRESENT);
        write_texel(0, '0);
        write_texel(1, '1);
        write_texel(2, 32'h00A5_5A00);
        write_texel(3, 32'h7F12_3456);
        write_texel('1, $urandom);
        sample_at(COORD_MIN, COORD_MIN);
        sample_at(COORD_MAX, COORD_MAX);
        sample_at('0, '0);
        sample_at(COORD_ONE, COORD_ONE);
        sample_at(COORD_NEG_LSB, COORD_NEG_LSB);
        sample_at(COORD_ONE - COORD_W'(1), COORD_ONE >> 1);

        // clamp to edge on both axes
        set_regs(2, 2, 1'b0, 1'b0, STATUS_PRESENT);
        sample_at(COORD_MIN, COORD_MAX);
        sample_at(COORD_ONE, COORD_ONE + COORD_W'(1));
        sample_at(COORD_NEG_LSB, COORD_ONE - COORD_W'(1));

        // zero sizes act as one
        set_regs(0, 0, 1'b1, 1'b0, STATUS_PRESENT);
        sample_at(COORD_MAX, COORD_MIN);

        for (p = 0; p < PHASES; p++)
        begin
            w  = SIZE_W'($urandom_range(1, 20));
            h  = SIZE_W'($urandom_range(1, 20));
            ws = $urandom_range(0, 1) != 0;
            wt = $urandom_range(0, 1) != 0;
            st = STATUS_PRESENT;
            case (p)
                0:
                begin
                    w  = 2048;
                    h  = 2048;
                    ws = 1'b0;
                    wt = 1'b1;
                end
                1:
                begin
                    w = '1;
                    h = '1;
                end
                2:
                begin
                    w = '1;
                    h = 1;
                end
                3:
                begin
                    w = 1;
                    h = '1;
                end
                4: w = 0;
                5: st = STATUS_FAILED;
                6: st = STATUS_NONE;
                7: st = STATUS_SPARE;
                default: ;
            endcase
            set_regs(w, h, ws, wt, st);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // stall the receiver long enough to back the pipeline up to the input
                if (p == 9 && i == 4)
                    hold_req = 1'b1;
                case ($urandom_range(0, 9))
                    0: write_texel(TEXEL_ADDR_W'($urandom), $urandom);
                    1, 2: write_texel(texel_index(pick_coord(), pick_coord()), $urandom);
                    default: sample_at(pick_coord(), pick_coord());
                endcase
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d texel writes and %0d samples over %0d register settings:",
                 writes_sent, samples_sent, settings_used);
        $display("sizes 0 to 4095, repeat and clamp, every texture state, one long stall.");
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
